// File: design/svalloc_pkg.sv
// Shared codes, command and status types of the voice allocator.
package svalloc_pkg;

	localparam logic [1:0] REQ_ON     = 2'd0;
	localparam logic [1:0] REQ_OFF    = 2'd1;
	localparam logic [1:0] REQ_SILENT = 2'd2;

	localparam logic [1:0] PH_FREE     = 2'd0;
	localparam logic [1:0] PH_ENGAGED  = 2'd1;
	localparam logic [1:0] PH_RELEASED = 2'd2;

	localparam logic [2:0] ST_NEW      = 3'd0;
	localparam logic [2:0] ST_ALREADY  = 3'd1;
	localparam logic [2:0] ST_NOFREE   = 3'd2;
	localparam logic [2:0] ST_RELEASED = 3'd3;
	localparam logic [2:0] ST_NOTENG   = 3'd4;
	localparam logic [2:0] ST_FREED    = 3'd5;
	localparam logic [2:0] ST_IGNORED  = 3'd6;

	localparam logic [1:0] MODE_NORMAL = 2'd0;

	typedef struct packed {
		logic load;
		logic scan;
		logic pop;
		logic commit;
		logic emit;
	} svalloc_cmd_t;

	typedef struct packed {
		logic [1:0] req_in;
		logic [1:0] req;
		logic       scan_last;
		logic       out_free;
	} svalloc_sts_t;

endpackage

// File: design/svalloc_dp.sv
// Datapath of the voice allocator: voice tables, free stack, counters and result register.
module svalloc_dp #(
	parameter int VOICES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_wdata,
	input  logic [15:0]               in_tdata,
	input  logic [1:0]                in_tuser,
	output logic                      out_tvalid,
	input  logic                      out_tready,
	output logic [15:0]               out_tdata,
	output logic [2:0]                out_tuser,
	input  svalloc_pkg::svalloc_cmd_t cmd,
	output svalloc_pkg::svalloc_sts_t sts
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);
	localparam logic [VW-1:0] LAST = VW'(VOICES - 1);
	localparam logic [CW-1:0] FULL = CW'(VOICES);

	logic [1:0]    mode_q;
	logic [1:0]    req_q;
	logic [6:0]    note_q;
	logic [3:0]    sv_q;
	logic [VW-1:0] cnt_q;
	logic [1:0]    phase_q [VOICES];
	logic [6:0]    note_mem [VOICES];
	logic [VW-1:0] stk_mem [VOICES];
	logic [VOICES-1:0] stk_wr_q;
	logic [CW-1:0] fc_q;
	logic [CW-1:0] eng_q;

	logic          scan_vld_s1;
	logic [1:0]    phase_s1;
	logic [6:0]    note_s1;
	logic [VW-1:0] idx_s1;
	logic          hit_q;
	logic [VW-1:0] hit_idx_q;

	logic [VW-1:0] stk_s1;
	logic          stk_ok_s1;
	logic [VW-1:0] stk_idx_s1;

	logic          out_valid_q;
	logic [15:0]   out_data_q;
	logic [2:0]    out_user_q;
	logic [15:0]   res_data_q;
	logic [2:0]    res_user_q;

	logic [VW:0]   cnt_ext;
	logic [VW+3:0] sv_ext;
	logic          sv_ok;
	logic [1:0]    phase_rd;
	logic          match;
	logic [CW-1:0] fc_m1;
	logic [VW-1:0] pop_addr;
	logic [VW-1:0] pop_v;

	logic [2:0]    status;
	logic [VW-1:0] voice_ix;
	logic          voice_raw;
	logic [3:0]    voice4;
	logic [VW+3:0] voice_ext;
	logic          ph_we;
	logic [VW-1:0] ph_idx;
	logic [1:0]    ph_val;
	logic          nm_we;
	logic          stk_we;
	logic [CW-1:0] fc_nxt;
	logic [CW-1:0] eng_nxt;
	logic [CW+4:0] eng_ext;
	logic          can;

	assign cnt_ext  = {1'b0, cnt_q};
	assign sv_ext   = {{VW{1'b0}}, sv_q};
	assign sv_ok    = sv_ext < (VW + 4)'(VOICES);
	assign phase_rd = (cnt_ext < (VW + 1)'(VOICES)) ? phase_q[cnt_q] : svalloc_pkg::PH_FREE;
	assign match    = scan_vld_s1 && (phase_s1 == svalloc_pkg::PH_ENGAGED) && (note_s1 == note_q);
	assign fc_m1    = fc_q - 1'b1;
	assign pop_addr = fc_m1[VW-1:0];
	// An entry never pushed is not reset in memory; it reads as its own index instead.
	assign pop_v    = stk_ok_s1 ? stk_s1 : stk_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= svalloc_pkg::MODE_NORMAL;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= in_tuser;
			note_q <= in_tdata[6:0];
			sv_q   <= in_tdata[10:7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			if (in_tuser == svalloc_pkg::REQ_SILENT) begin
				cnt_q <= {{VW{1'b0}}, in_tdata[10:7]} >> 0 == '0 ? '0 : VW'({{VW{1'b0}}, in_tdata[10:7]});
			end else begin
				cnt_q <= '0;
			end
		end else if (cmd.scan) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Scan stage: one voice is read per cycle and compared in the next.
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			phase_s1 <= phase_rd;
			note_s1  <= note_mem[cnt_q];
			idx_s1   <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
		end else begin
			scan_vld_s1 <= cmd.scan;
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			stk_s1     <= stk_mem[pop_addr];
			stk_ok_s1  <= stk_wr_q[pop_addr];
			stk_idx_s1 <= pop_addr;
		end
	end

	always_comb begin
		status    = svalloc_pkg::ST_IGNORED;
		voice_ix  = '0;
		voice_raw = 1'b0;
		ph_we     = 1'b0;
		ph_idx    = cnt_q;
		ph_val    = svalloc_pkg::PH_FREE;
		nm_we     = 1'b0;
		stk_we    = 1'b0;
		fc_nxt    = fc_q;
		eng_nxt   = eng_q;
		case (req_q)
			svalloc_pkg::REQ_ON: begin
				if (hit_q) begin
					status   = svalloc_pkg::ST_ALREADY;
					voice_ix = hit_idx_q;
				end else if (fc_q != '0) begin
					status   = svalloc_pkg::ST_NEW;
					voice_ix = pop_v;
					ph_we    = 1'b1;
					ph_idx   = pop_v;
					ph_val   = svalloc_pkg::PH_ENGAGED;
					nm_we    = 1'b1;
					fc_nxt   = fc_m1;
					eng_nxt  = eng_q + 1'b1;
				end else begin
					status = svalloc_pkg::ST_NOFREE;
				end
			end
			svalloc_pkg::REQ_OFF: begin
				if (hit_q) begin
					status   = svalloc_pkg::ST_RELEASED;
					voice_ix = hit_idx_q;
					ph_we    = 1'b1;
					ph_idx   = hit_idx_q;
					ph_val   = svalloc_pkg::PH_RELEASED;
					if (eng_q != '0) begin
						eng_nxt = eng_q - 1'b1;
					end
				end else begin
					status = svalloc_pkg::ST_NOTENG;
				end
			end
			svalloc_pkg::REQ_SILENT: begin
				voice_raw = 1'b1;
				if (sv_ok && (phase_rd == svalloc_pkg::PH_RELEASED)) begin
					status = svalloc_pkg::ST_FREED;
					ph_we  = 1'b1;
					ph_val = svalloc_pkg::PH_FREE;
					if (fc_q < FULL) begin
						stk_we = 1'b1;
						fc_nxt = fc_q + 1'b1;
					end
				end
			end
			default: begin
				status = svalloc_pkg::ST_IGNORED;
			end
		endcase
	end

	assign voice_ext = {4'b0, voice_ix};
	assign voice4    = voice_raw ? sv_q : voice_ext[3:0];
	assign eng_ext   = {5'b0, eng_nxt};
	assign can       = (mode_q == svalloc_pkg::MODE_NORMAL) ? (eng_nxt < FULL) : (eng_nxt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '{default: svalloc_pkg::PH_FREE};
			stk_wr_q <= '0;
			fc_q     <= FULL;
			eng_q    <= '0;
		end else if (cmd.commit) begin
			if (ph_we) begin
				phase_q[ph_idx] <= ph_val;
			end
			if (stk_we) begin
				stk_wr_q[fc_q[VW-1:0]] <= 1'b1;
			end
			fc_q  <= fc_nxt;
			eng_q <= eng_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && nm_we) begin
			note_mem[ph_idx] <= note_q;
		end
		if (cmd.commit && stk_we) begin
			stk_mem[fc_q[VW-1:0]] <= cnt_q;
		end
		if (cmd.commit) begin
			res_user_q <= status;
			res_data_q <= {5'b0, can, (eng_nxt != '0), eng_ext[4:0], voice4};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= res_data_q;
			out_user_q <= res_user_q;
		end
	end

	assign out_tvalid    = out_valid_q;
	assign out_tdata     = out_data_q;
	assign out_tuser     = out_user_q;
	assign sts.req_in    = in_tuser;
	assign sts.req       = req_q;
	assign sts.scan_last = (cnt_q == LAST);
	assign sts.out_free  = !out_valid_q || out_tready;

	// A voice is engaged or released only while it is off the free stack.
	ap_pool: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, eng_q} + {1'b0, fc_q}) <= (CW + 1)'(VOICES))
		else $error("engaged plus free voices exceed the pool");

	ap_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FULL)
		else $error("free stack count beyond the pool size");

	ap_eng_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(eng_q))
		else $error("engaged count changed outside a commit");

endmodule

// File: design/svalloc_ctrl.sv
// Controller state machine of the voice allocator.
module svalloc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  svalloc_pkg::svalloc_sts_t sts,
	output svalloc_pkg::svalloc_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DRAIN  = 6'b000100,
		S_POP    = 6'b001000,
		S_COMMIT = 6'b010000,
		S_EMIT   = 6'b100000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if ((sts.req_in == svalloc_pkg::REQ_ON) ||
					    (sts.req_in == svalloc_pkg::REQ_OFF)) begin
						state_nxt = S_SCAN;
					end else begin
						state_nxt = S_COMMIT;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last voice read is compared during this cycle.
				state_nxt = (sts.req == svalloc_pkg::REQ_ON) ? S_POP : S_COMMIT;
			end
			S_POP: begin
				cmd.pop   = 1'b1;
				state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	ap_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transfer accepted while an event is in work");

	ap_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over an untaken result");

	ap_single_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit)
		else $error("one event committed twice");

endmodule

// File: design/synth_voice_allocator.sv
// A note on or note off first searches for the note's voice, reading one voice a cycle from
// the voice tables; a note on then pops the free stack. A voice-silent event or an unused
// request type skips both. No new event is taken until its result is loaded into the output
// register. A finished result waits there, so the next event can be accepted while the
// previous result is not yet taken.
// Reset leaves all voices free with the free stack holding voice 0 at the bottom.
module synth_voice_allocator #(
	parameter int VOICES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,     // note_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // note[6:0], silent_voice[10:7], zero fill
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // voice[3:0], engaged_count[8:4], has_engaged[9],
	                                   // can_engage[10], zero fill
	output logic [2:0]  m_axis_tuser   // status[2:0]
);

	svalloc_pkg::svalloc_cmd_t cmd;
	svalloc_pkg::svalloc_sts_t sts;

	svalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	svalloc_dp #(
		.VOICES (VOICES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

// File: dv/synth_voice_allocator_checker.sv
// Checker for the voice allocator: watches both streams and the mode register, predicts, compares.
module synth_voice_allocator_checker #(
	parameter int VOICES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	output int          mismatches,
	output int          outstanding,
	output int          results_checked,
	output int          nofree_seen,
	output int          freed_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] voice;
		logic [4:0] engaged;
		logic       has_eng;
		logic       can_eng;
	} voice_result_t;

	logic [6:0]    held_note   [VOICES];
	logic [1:0]    voice_phase [VOICES];
	logic [3:0]    free_stack  [VOICES];
	int            free_depth;
	int            engaged_total;
	logic [1:0]    note_mode;
	voice_result_t pending_results [$];

	// Lowest voice that is engaged on this key, or VOICES when there is none.
	function automatic int engaged_voice_of(input logic [6:0] key);
		for (int v = 0; v < VOICES; v++) begin
			if (voice_phase[v] == svalloc_pkg::PH_ENGAGED && held_note[v] == key)
				return v;
		end
		return VOICES;
	endfunction

	function automatic voice_result_t allocate_voice(input logic [1:0] req, input logic [6:0] key,
			input logic [3:0] silent);
		voice_result_t r;
		int            v;
		r.status = svalloc_pkg::ST_IGNORED;
		r.voice  = '0;
		case (req)
			svalloc_pkg::REQ_ON: begin
				v = engaged_voice_of(key);
				if (v < VOICES) begin
					r.status = svalloc_pkg::ST_ALREADY;
					r.voice  = 4'(v);
				end else if (free_depth > 0) begin
					free_depth--;
					v = int'(free_stack[free_depth]);
					voice_phase[v] = svalloc_pkg::PH_ENGAGED;
					held_note[v]   = key;
					engaged_total++;
					r.status = svalloc_pkg::ST_NEW;
					r.voice  = 4'(v);
				end else begin
					r.status = svalloc_pkg::ST_NOFREE;
				end
			end
			svalloc_pkg::REQ_OFF: begin
				v = engaged_voice_of(key);
				if (v < VOICES) begin
					voice_phase[v] = svalloc_pkg::PH_RELEASED;
					if (engaged_total > 0)
						engaged_total--;
					r.status = svalloc_pkg::ST_RELEASED;
					r.voice  = 4'(v);
				end else begin
					r.status = svalloc_pkg::ST_NOTENG;
				end
			end
			svalloc_pkg::REQ_SILENT: begin
				r.voice = silent;
				if (int'(silent) < VOICES &&
				    voice_phase[silent] == svalloc_pkg::PH_RELEASED) begin
					voice_phase[silent] = svalloc_pkg::PH_FREE;
					// A push onto a full stack is dropped.
					if (free_depth < VOICES) begin
						free_stack[free_depth] = silent;
						free_depth++;
					end
					r.status = svalloc_pkg::ST_FREED;
				end
			end
			default: ;
		endcase
		r.engaged = 5'(engaged_total);
		r.has_eng = engaged_total > 0;
		r.can_eng = (note_mode == svalloc_pkg::MODE_NORMAL) ? (engaged_total < VOICES)
			: (engaged_total == 0);
		return r;
	endfunction

	task automatic check_field(input string field, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		voice_result_t got;
		voice_result_t want;
		voice_result_t pred;
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				held_note[v]   = '0;
				voice_phase[v] = svalloc_pkg::PH_FREE;
				free_stack[v]  = 4'(v);
			end
			free_depth      = VOICES;
			engaged_total   = 0;
			note_mode       = svalloc_pkg::MODE_NORMAL;
			pending_results = {};
			mismatches      = 0;
			outstanding     = 0;
			results_checked = 0;
			nofree_seen     = 0;
			freed_seen      = 0;
		end else begin
			// Results leave before the event taken at the same edge is predicted.
			if (m_axis_tvalid && m_axis_tready) begin
				got.status  = m_axis_tuser;
				got.voice   = m_axis_tdata[3:0];
				got.engaged = m_axis_tdata[8:4];
				got.has_eng = m_axis_tdata[9];
				got.can_eng = m_axis_tdata[10];
				if (pending_results.size() == 0) begin
					$display("%0t: result with no event pending, expected nothing, %s %0d voice %0d",
						$time, "got status", got.status, got.voice);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (want.status == svalloc_pkg::ST_NOFREE)
						nofree_seen++;
					if (want.status == svalloc_pkg::ST_FREED)
						freed_seen++;
					check_field("status", want.status, got.status);
					check_field("voice", want.voice, got.voice);
					check_field("engaged_count", want.engaged, got.engaged);
					check_field("has_engaged", want.has_eng, got.has_eng);
					check_field("can_engage", want.can_eng, got.can_eng);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pred = allocate_voice(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[10:7]);
				pending_results = {pending_results, pred};
			end
			if (cfg_we)
				note_mode = cfg_wdata;
			outstanding = pending_results.size();
		end
	end

endmodule

// File: dv/synth_voice_allocator_tb.sv
// Testbench top for the voice allocator: clock, reset, note event stimulus and the verdict.
module synth_voice_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         VOICES         = 16;
	localparam int         HALF_PERIOD    = 6;
	localparam int         HOLD_CYCLES    = 200;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         SETTLE_CYCLES  = 2 * VOICES + 10;
	localparam logic [1:0] MODE_PORTA     = 2'd1;
	localparam logic [1:0] MODE_ARP       = 2'd2;
	localparam logic [1:0] MODE_SPARE     = 2'd3;
	localparam logic [1:0] REQ_SPARE      = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // note[6:0], silent_voice[10:7], zero fill
	logic [1:0]  s_axis_tuser;   // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // voice[3:0], engaged_count[8:4], has_engaged[9], can_engage[10]
	logic [2:0]  m_axis_tuser;   // status[2:0]

	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_off;
	int   events_sent;
	int   idle_cycles;
	int   mismatches;
	int   outstanding;
	int   results_checked;
	int   nofree_seen;
	int   freed_seen;

	synth_voice_allocator #(.VOICES(VOICES)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	synth_voice_allocator_checker #(.VOICES(VOICES)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.nofree_seen     (nofree_seen),
		.freed_seen      (freed_seen)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_event(input logic [1:0] req, input logic [6:0] key, input logic [3:0] silent);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, silent, key};
		s_axis_tuser  <= req;
		do @(posedge clk); while (!s_axis_tready);
		events_sent++;
		@(negedge clk);
	endtask

	// The mode is only changed once every result is out and the block has had time to settle.
	task automatic set_mode(input logic [1:0] mode);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a small pool of keys so that note-offs and repeats find their voices.
	function automatic logic [6:0] pick_note();
		int idx;
		if ($urandom_range(99) < 15)
			return 7'($urandom_range(127));
		idx = $urandom_range(23);
		if (idx == 0)
			return 7'd0;
		if (idx == 23)
			return 7'd127;
		return 7'(39 + idx);
	endfunction

	// Alternates stretches that fill the pool with stretches that drain it, silencing every voice halfway.
	task automatic random_phase(input int count);
		int   r;
		logic filling;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) begin
				for (int v = 0; v < VOICES; v++)
					send_event(svalloc_pkg::REQ_SILENT, 7'($urandom_range(127)), 4'(v));
			end
			filling = ((n / 12) % 2) == 0;
			r = $urandom_range(99);
			if (r < (filling ? 55 : 20))
				send_event(svalloc_pkg::REQ_ON, pick_note(), 4'($urandom_range(15)));
			else if (r < (filling ? 75 : 60))
				send_event(svalloc_pkg::REQ_OFF, pick_note(), 4'($urandom_range(15)));
			else if (r < 97)
				send_event(svalloc_pkg::REQ_SILENT, 7'($urandom_range(127)),
					4'($urandom_range(15)));
			else
				send_event(REQ_SPARE, 7'($urandom_range(127)), 4'($urandom_range(15)));
		end
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, outstanding);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = svalloc_pkg::REQ_ON;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off       = 1'b0;
		events_sent    = 0;
		idle_cycles    = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_mode(svalloc_pkg::MODE_NORMAL);
		// Lowest and highest keys, a repeat, note-offs with and without a voice,
		// silence on engaged, free and released voices, and the unused request.
		send_event(svalloc_pkg::REQ_ON, 7'd0, 4'd0);
		send_event(svalloc_pkg::REQ_ON, 7'd127, 4'd15);
		send_event(svalloc_pkg::REQ_ON, 7'd0, 4'd15);
		send_event(svalloc_pkg::REQ_OFF, 7'd127, 4'd0);
		send_event(svalloc_pkg::REQ_OFF, 7'd127, 4'd15);
		send_event(svalloc_pkg::REQ_SILENT, 7'd127, 4'd15);
		send_event(svalloc_pkg::REQ_SILENT, 7'd0, 4'd0);
		send_event(svalloc_pkg::REQ_SILENT, 7'd0, 4'd14);
		send_event(REQ_SPARE, 7'd127, 4'd15);
		// Fill the whole pool, then ask for one voice more.
		for (int k = 40; k < 40 + VOICES - 1; k++)
			send_event(svalloc_pkg::REQ_ON, 7'(k), 4'(k));
		send_event(svalloc_pkg::REQ_ON, 7'd99, 4'd0);
		random_phase(72);

		set_mode(MODE_PORTA);
		send_idle_pct = 49;
		random_phase(72);

		set_mode(MODE_ARP);
		send_idle_pct  = 0;
		recv_stall_pct = 49;
		random_phase(72);

		set_mode(MODE_SPARE);
		send_idle_pct  = 25;
		recv_stall_pct = 25;
		random_phase(72);

		// The receiver holds off while events keep coming, so the input backs up.
		set_mode(svalloc_pkg::MODE_NORMAL);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off       = 1'b1;
		random_phase(72);

		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Sent %0d note events under all four note modes; %0d results compared.",
			events_sent, results_checked);
		$display("Pool exhausted %0d times, %0d released voices returned to the pool.",
			nofree_seen, freed_seen);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
